### rtl/core/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// shared types and constants of the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int LINE_WIDTH_DEF  = 20;
  localparam int CHAR_W          = 8;
  localparam int LINE_OUT_W      = 20;

  // character codes
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NONE    = 8'h00;

  typedef enum logic [1:0] {
    EV_UNPAIRED  = 2'd0,
    EV_UNDERFLOW = 2'd1,
    EV_OVERFLOW  = 2'd2,
    EV_DONE      = 2'd3
  } bbc_event_t;

  typedef enum logic {
    S_RUN   = 1'b0,
    S_DRAIN = 1'b1
  } bbc_state_t;

  // shift command broadcast along the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

endpackage

### rtl/core/bracket_balance_checker.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker
// checks bracket nesting of a byte stream and reports unmatched brackets
// ----------------------------------------------------------------------------
// usage:
//   in_* channel: one transfer per text byte (in_tuser = 0) or an end-of-text
//   marker (in_tuser = 1). out_* channel: event reports, out_tlast marks the
//   final report caused by one input transfer.
//   with the output free the block takes one text byte per cycle. a report
//   leaves the output register in the cycle after the byte that caused it.
//   end of text drains the stack through cell 0, one entry per cycle while
//   the output is free, then reports done; no input is taken meanwhile.
//   the stack is a chain of cells that all shift in the same cycle: down on
//   push, up on pop; the top of stack always sits in cell 0.
//   reset empties the stack (count to zero) and sets the line counter to 1.
//   a stalled receiver holds the output register and in_tready drops until
//   the pending report is taken.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
  parameter int LINE_WIDTH  = bbc_pkg::LINE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] bracket_char, [27:8] src_line, rest zero
  output logic [1:0]  out_tuser,  // [1:0] event_res
  output logic        out_tlast   // last_of_run
);
  import bbc_pkg::*;

  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W = CHAR_W + LINE_WIDTH;

  // control
  bbc_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [LINE_WIDTH-1:0]  line_r, line_nxt;
  stk_op_t                op;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  bbc_event_t             out_ev_r, out_ev_nxt;
  logic [CHAR_W-1:0]      out_ch_r, out_ch_nxt;
  logic [LINE_OUT_W-1:0]  out_line_r, out_line_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_load;

  logic                   slot_free;
  logic                   in_fire;
  logic [ENTRY_W-1:0]     push_entry;
  logic [ENTRY_W-1:0]     cell_q [STACK_DEPTH];

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_RUN) && slot_free;
  assign in_fire    = in_tvalid && in_tready;
  assign push_entry = {line_r, in_tdata};

  // stack cell chain, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] below;
    logic [ENTRY_W-1:0] above;
    if (i == 0) begin : g_first
      assign below = push_entry;
    end else begin : g_mid
      assign below = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign above = cell_q[i];
    end else begin : g_inner
      assign above = cell_q[i+1];
    end
    bbc_cell #(
      .ENTRY_W (ENTRY_W)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .below_i (below),
      .above_i (above),
      .entry_o (cell_q[i])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    line_nxt     = line_r;
    op           = '0;
    out_load     = 1'b0;
    out_ev_nxt   = out_ev_r;
    out_ch_nxt   = out_ch_r;
    out_line_nxt = out_line_r;
    out_last_nxt = out_last_r;

    case (state_r)
      S_RUN: begin
        if (in_fire) begin
          if (in_tuser) begin
            state_nxt = S_DRAIN;
          end else begin
            case (in_tdata)
              CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
                if (cnt_r < CNT_W'(STACK_DEPTH)) begin
                  op.push = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                end else begin
                  // full stack: opener dropped
                  out_load     = 1'b1;
                  out_ev_nxt   = EV_OVERFLOW;
                  out_ch_nxt   = in_tdata;
                  out_line_nxt = LINE_OUT_W'(line_r);
                  out_last_nxt = 1'b1;
                end
              end
              CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
                // any closer pops, kind not compared
                if (cnt_r != '0) begin
                  op.pop  = 1'b1;
                  cnt_nxt = cnt_r - 1'b1;
                end else begin
                  out_load     = 1'b1;
                  out_ev_nxt   = EV_UNDERFLOW;
                  out_ch_nxt   = in_tdata;
                  out_line_nxt = LINE_OUT_W'(line_r);
                  out_last_nxt = 1'b1;
                end
              end
              CH_NEWLINE: begin
                // saturating line counter
                if (line_r != '1) begin
                  line_nxt = line_r + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_DRAIN: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (cnt_r != '0) begin
            op.pop       = 1'b1;
            cnt_nxt      = cnt_r - 1'b1;
            out_ev_nxt   = EV_UNPAIRED;
            out_ch_nxt   = cell_q[0][CHAR_W-1:0];
            out_line_nxt = LINE_OUT_W'(cell_q[0][ENTRY_W-1:CHAR_W]);
            out_last_nxt = 1'b0;
          end else begin
            out_ev_nxt   = EV_DONE;
            out_ch_nxt   = CH_NONE;
            out_line_nxt = LINE_OUT_W'(line_r);
            out_last_nxt = 1'b1;
            line_nxt     = LINE_WIDTH'(1);
            state_nxt    = S_RUN;
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      cnt_r       <= '0;
      line_r      <= LINE_WIDTH'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // report payload, no reset needed
  always_ff @(posedge clk) begin
    out_ev_r   <= out_ev_nxt;
    out_ch_r   <= out_ch_nxt;
    out_line_r <= out_line_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_line_r, out_ch_r};

`ifndef ASSERT_OFF
  // fill count never passes the chain length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // no input is taken while the stack drains
  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> !in_tready)
    else $error("input ready during drain");

  // done report always closes the run and carries no character
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == EV_DONE) |-> (out_tlast && out_tdata[7:0] == CH_NONE))
    else $error("done report malformed");

  // leaving the drain empties the stack and restarts the line count
  a_drain_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && state_nxt == S_RUN) |=>
      (cnt_r == '0 && line_r == LINE_WIDTH'(1)))
    else $error("drain exit left state behind");
`endif

endmodule

### rtl/core/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell
// one stack slot: takes the entry below on push, the entry above on pop
// ----------------------------------------------------------------------------
module bbc_cell #(
  parameter int ENTRY_W = 28
) (
  input  logic                 clk,
  input  bbc_pkg::stk_op_t     op,
  input  logic [ENTRY_W-1:0]   below_i,
  input  logic [ENTRY_W-1:0]   above_i,
  output logic [ENTRY_W-1:0]   entry_o
);
  import bbc_pkg::*;

  logic [ENTRY_W-1:0] entry_r;
  logic [ENTRY_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (op.push) begin
      entry_nxt = below_i;
    end else if (op.pop) begin
      entry_nxt = above_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule
